FILE: hw/rtl/orbcam_pkg.sv
// Package for the orbit camera block: sequencer states, CORDIC arctangent table,
// reset defaults and the Q1.15 rounding helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package orbcam_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 32;
    localparam int CORDIC_STEPS   = 24;
    localparam int CW             = 34;
    localparam int PW             = 57;

    localparam logic [23:0] RADIUS_RESET = 24'd2560;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    localparam logic [7:0] REG_RADIUS   = 8'd0;
    localparam logic [7:0] REG_TARGET_X = 8'd1;
    localparam logic [7:0] REG_TARGET_Y = 8'd2;
    localparam logic [7:0] REG_TARGET_Z = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORD,
        ST_CRND,
        ST_MULA,
        ST_MULB,
        ST_RND,
        ST_SUM
    } t_state;

    function automatic logic signed [CW-1:0] atan_of(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051E;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh00000A2FA;
            5'd15: v = 34'sh00000517D;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A30;
            5'd19: v = 34'sh000000518;
            5'd20: v = 34'sh00000028C;
            5'd21: v = 34'sh000000146;
            5'd22: v = 34'sh0000000A3;
            5'd23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round half away from zero by 15 bits and saturate to Q1.15.
    function automatic logic signed [15:0] round_q15(input logic signed [CW-1:0] v);
        logic               neg;
        logic [CW-1:0]      mag;
        logic [CW-1:0]      t;
        logic signed [CW-1:0] s;
        logic signed [15:0] res;
        neg = v[CW-1];
        mag = neg ? CW'(-v) : CW'(v);
        t   = (mag + CW'(1 << 14)) >> 15;
        s   = neg ? -$signed(t) : $signed(t);
        if (s > 34'sd32767) begin
            res = 16'sd32767;
        end else if (s < -34'sd32768) begin
            res = -16'sd32768;
        end else begin
            res = s[15:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/orbit_camera_position.sv
// Orbit camera top level: angle update, shared CORDIC, bit-serial multipliers,
// rounding and saturation. Depends on orbcam_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted transfer adds the two angle deltas to the stored azimuth and
// elevation, clamps azimuth to +-0.49 pi and elevation to 0 .. 0.49 pi, and
// produces one camera position on a sphere of the configured radius around the
// configured target. From acceptance to result, a single CORDIC rotator runs 24
// steps for the azimuth and 24 for the elevation (each followed by a rounding
// step), two bit-serial multipliers form r*cos/sin(el) and then the products
// with sin/cos(az), and ST_RND rounds and ST_SUM adds the target. The
// next item is taken once the sequencer returns to idle; a finished result waits
// in the output register meanwhile. Configuration writes are always accepted.
module orbit_camera_position #(
    parameter int ANGLE_BITS = orbcam_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = orbcam_pkg::COORD_BITS_DEF,
    parameter int SW_BYTES   = (2 * ANGLE_BITS + 7) / 8,
    parameter int MW_BYTES   = (3 * COORD_BITS + 2 * ANGLE_BITS - 3 + 7) / 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    // azimuth_delta, elevation_delta
    input  wire logic [SW_BYTES*8-1:0]   i_s_tdata,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    // pos_x, pos_y, pos_z, azimuth_now, elevation_now
    output logic [MW_BYTES*8-1:0]        o_m_tdata,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [7:0]              i_cfg_index,
    input  wire logic [31:0]             i_cfg_data
);
    import orbcam_pkg::*;

    localparam int A       = ANGLE_BITS;
    localparam int ZSH     = 32 - ANGLE_BITS;
    localparam int AZ_LIMIT = (49 * (1 << (ANGLE_BITS - 1))) / 100;
    localparam int SW      = ((COORD_BITS > CW) ? COORD_BITS : CW) + 1;
    localparam int OUTW    = 3 * COORD_BITS + 2 * ANGLE_BITS - 3;
    localparam logic signed [A:0] AZ_LIM = (A + 1)'(AZ_LIMIT);
    localparam logic signed [SW-1:0] C_HI =
        {{(SW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] C_LO = ~C_HI;

    t_state r_state, n_state;

    logic [23:0]               r_radius;
    logic signed [31:0]        r_tx, r_ty, r_tz;
    logic signed [A-1:0]       r_az, n_az;
    logic [A-2:0]              r_el, n_el;
    logic signed [CW-1:0]      r_x, r_y, r_z, n_x, n_y, n_z;
    logic [4:0]                r_cnt, n_cnt;
    logic                      r_sel, n_sel;
    logic signed [15:0]        r_sa, r_ca, r_se, r_ce, n_sa, n_ca, n_se, n_ce;
    logic signed [PW-1:0]      r_mc, n_mc;
    logic [15:0]               r_b0, r_b1, n_b0, n_b1;
    logic signed [PW-1:0]      r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic signed [CW-1:0]      r_ox, r_oy, r_oz, n_ox, n_oy, n_oz;
    logic                      r_mvalid, n_mvalid;
    logic [OUTW-1:0]           r_mdata, n_mdata;

    logic signed [A-1:0]       d_az, d_el;
    logic signed [A:0]         az_sum, el_sum, az_cl, el_cl;
    logic signed [CW-1:0]      dx, dy, atn;
    logic signed [PW-1:0]      add0, add1;
    logic                      last_bit;

    assign d_az = i_s_tdata[A-1:0];
    assign d_el = i_s_tdata[2*A-1:A];
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_mvalid;
    assign o_m_tdata   = {{(MW_BYTES * 8 - OUTW){1'b0}}, r_mdata};

    function automatic logic signed [CW-1:0] round_by(input logic signed [PW-1:0] p,
                                                      input int s);
        logic          neg;
        logic [PW-1:0] mag;
        logic [PW-1:0] t;
        neg = p[PW-1];
        mag = neg ? PW'(-p) : PW'(p);
        t   = (mag + (PW'(1) << (s - 1))) >> s;
        return neg ? -$signed(t[CW-1:0]) : $signed(t[CW-1:0]);
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_add(input logic signed [31:0] t,
                                                      input logic signed [CW-1:0] o);
        logic signed [SW-1:0] s;
        s = SW'(t) + SW'(o);
        if (s > C_HI) begin
            s = C_HI;
        end else if (s < C_LO) begin
            s = C_LO;
        end
        return s[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_tx <= '0;
            r_ty <= '0;
            r_tz <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIUS:   r_radius <= i_cfg_data[23:0];
                REG_TARGET_X: r_tx <= i_cfg_data;
                REG_TARGET_Y: r_ty <= i_cfg_data;
                REG_TARGET_Z: r_tz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_az     <= '0;
            r_el     <= '0;
            r_cnt    <= '0;
            r_sel    <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_az     <= n_az;
            r_el     <= n_el;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_mvalid <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_sa <= n_sa;
        r_ca <= n_ca;
        r_se <= n_se;
        r_ce <= n_ce;
        r_mc <= n_mc;
        r_b0 <= n_b0;
        r_b1 <= n_b1;
        r_px <= n_px;
        r_py <= n_py;
        r_pz <= n_pz;
        r_ox <= n_ox;
        r_oy <= n_oy;
        r_oz <= n_oz;
        r_mdata <= n_mdata;
    end

    always_comb begin
        az_sum = {r_az[A-1], r_az} + {d_az[A-1], d_az};
        el_sum = $signed({2'b00, r_el}) + {d_el[A-1], d_el};
        if (az_sum > AZ_LIM) begin
            az_cl = AZ_LIM;
        end else if (az_sum < -AZ_LIM) begin
            az_cl = -AZ_LIM;
        end else begin
            az_cl = az_sum;
        end
        if (el_sum > AZ_LIM) begin
            el_cl = AZ_LIM;
        end else if (el_sum < 0) begin
            el_cl = '0;
        end else begin
            el_cl = el_sum;
        end

        dx  = r_y >>> r_cnt;
        dy  = r_x >>> r_cnt;
        atn = atan_of(r_cnt);

        last_bit = (r_cnt == 5'd15);
        add0 = r_b0[0] ? (last_bit ? -r_mc : r_mc) : '0;
        add1 = r_b1[0] ? (last_bit ? -r_mc : r_mc) : '0;

        n_state = r_state;
        n_az = r_az;
        n_el = r_el;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_cnt = r_cnt;
        n_sel = r_sel;
        n_sa = r_sa;
        n_ca = r_ca;
        n_se = r_se;
        n_ce = r_ce;
        n_mc = r_mc;
        n_b0 = r_b0;
        n_b1 = r_b1;
        n_px = r_px;
        n_py = r_py;
        n_pz = r_pz;
        n_ox = r_ox;
        n_oy = r_oy;
        n_oz = r_oz;
        n_mdata = r_mdata;
        n_mvalid = r_mvalid && !i_m_tready;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_az  = az_cl[A-1:0];
                    n_el  = el_cl[A-2:0];
                    n_x   = CORDIC_GAIN;
                    n_y   = '0;
                    n_z   = {{(CW - A - 1){az_cl[A]}}, az_cl} <<< ZSH;
                    n_cnt = '0;
                    n_sel = 1'b0;
                    n_state = ST_CORD;
                end
            end
            ST_CORD: begin
                if (!r_z[CW-1]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - atn;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + atn;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    n_state = ST_CRND;
                end
            end
            ST_CRND: begin
                n_cnt = '0;
                if (!r_sel) begin
                    n_ca  = round_q15(r_x);
                    n_sa  = round_q15(r_y);
                    n_x   = CORDIC_GAIN;
                    n_y   = '0;
                    n_z   = {{(CW - A + 1){1'b0}}, r_el} <<< ZSH;
                    n_sel = 1'b1;
                    n_state = ST_CORD;
                end else begin
                    n_ce  = round_q15(r_x);
                    n_se  = round_q15(r_y);
                    n_mc  = {{(PW - 24){1'b0}}, r_radius};
                    n_b0  = round_q15(r_x);
                    n_b1  = round_q15(r_y);
                    n_px  = '0;
                    n_py  = '0;
                    n_state = ST_MULA;
                end
            end
            ST_MULA: begin
                n_px = r_px + add0;
                n_py = r_py + add1;
                n_mc = r_mc <<< 1;
                n_b0 = r_b0 >> 1;
                n_b1 = r_b1 >> 1;
                n_cnt = r_cnt + 5'd1;
                if (last_bit) begin
                    n_mc  = r_px + add0;
                    n_b0  = r_sa;
                    n_b1  = r_ca;
                    n_px  = '0;
                    n_pz  = '0;
                    n_cnt = '0;
                    n_state = ST_MULB;
                end
            end
            ST_MULB: begin
                n_px = r_px + add0;
                n_pz = r_pz + add1;
                n_mc = r_mc <<< 1;
                n_b0 = r_b0 >> 1;
                n_b1 = r_b1 >> 1;
                n_cnt = r_cnt + 5'd1;
                if (last_bit) begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                n_ox = round_by(r_px, 30);
                n_oy = round_by(r_py, 15);
                n_oz = round_by(r_pz, 30);
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (!r_mvalid || i_m_tready) begin
                    n_mdata = {r_el[A-3:0], r_az[A-2:0], sat_add(r_tz, r_oz),
                               sat_add(r_ty, r_oy), sat_add(r_tx, r_ox)};
                    n_mvalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_el_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $signed({1'b0, r_el}) <= AZ_LIM)
        else $error("elevation beyond limit");
    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed({r_az[A-1], r_az}) <= AZ_LIM) && ($signed({r_az[A-1], r_az}) >= -AZ_LIM))
        else $error("azimuth beyond limit");
    a_cord_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORD) |-> (r_cnt < 5'(CORDIC_STEPS)))
        else $error("cordic step count overrun");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) && (n_state == ST_IDLE) |=> o_m_tvalid)
        else $error("result not presented");
`endif

endmodule
`default_nettype wire
